FILE: rtl/fpps_pkg.sv
package fpps_pkg;

  // Process state codes as they are stored in the table.
  localparam logic [2:0] ST_READY      = 3'd0;
  localparam logic [2:0] ST_RUNNING    = 3'd1;
  localparam logic [2:0] ST_SLEEPING   = 3'd2;
  localparam logic [2:0] ST_PAUSED     = 3'd3;
  localparam logic [2:0] ST_BLOCKED    = 3'd4;
  localparam logic [2:0] ST_TERMINATED = 3'd5;

  localparam logic [4:0] ALARM_SIGNAL = 5'd14;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_SCHEDULE = 2'd1,
    CMD_SET_TICK = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_WRITTEN   = 2'd0,
    STAT_SCHEDULED = 2'd1,
    STAT_HALT      = 2'd2,
    STAT_DEADLOCK  = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [7:0]  prio;
    logic [31:0] wake;
    logic [31:0] alarm;
    logic [4:0]  sig;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{
    st:    ST_TERMINATED,
    prio:  8'd0,
    wake:  32'd0,
    alarm: 32'd0,
    sig:   5'd0
  };

  // Result of looking at one table entry during a scan pass.
  typedef struct packed {
    entry_t      upd;
    logic        wr;
    logic        alive;
    logic        ready;
    logic        evt;
    logic [31:0] evt_tick;
  } eval_t;

endpackage

FILE: rtl/fpps_in_if.sv
interface fpps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [3:0]  slot;
  logic [2:0]  proc_state;
  logic [7:0]  prio;
  logic [31:0] wake_at;
  logic [31:0] alarm_at;
  logic [4:0]  signal_in;
  logic [31:0] tick_value;

  modport source (
    output valid, cmd, slot, proc_state, prio, wake_at, alarm_at, signal_in, tick_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, slot, proc_state, prio, wake_at, alarm_at, signal_in, tick_value,
    output ready
  );
endinterface

FILE: rtl/fpps_out_if.sv
interface fpps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  chosen_slot;
  logic [31:0] now_tick;
  logic [4:0]  chosen_signal;

  modport source (
    output valid, status, chosen_slot, now_tick, chosen_signal,
    input  ready
  );
  modport sink (
    input  valid, status, chosen_slot, now_tick, chosen_signal,
    output ready
  );
endinterface

FILE: rtl/fpps_ram.sv
module fpps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/fpps_eval.sv
module fpps_eval (
  input  fpps_pkg::entry_t ent,
  input  logic             pass2,
  input  logic             is_run,
  input  logic [31:0]      first_tick,
  input  logic [31:0]      stop_tick,
  output fpps_pkg::eval_t  res
);

  logic [31:0]      t_wake;
  logic [31:0]      t_alarm;
  fpps_pkg::entry_t upd1;
  fpps_pkg::entry_t upd2;

  assign t_wake  = (ent.wake > first_tick) ? ent.wake : first_tick;
  assign t_alarm = (ent.alarm > first_tick) ? ent.alarm : first_tick;

  always_comb begin
    upd1 = ent;
    if (is_run && ent.st == fpps_pkg::ST_RUNNING) begin
      upd1.st = fpps_pkg::ST_READY;
    end

    // Time has advanced to the stop tick: wake sleepers and fire due alarms.
    upd2 = ent;
    if (ent.st == fpps_pkg::ST_SLEEPING && ent.wake <= stop_tick) begin
      upd2.st = fpps_pkg::ST_READY;
    end
    if (ent.alarm != 32'd0 && ent.alarm <= stop_tick) begin
      upd2.sig   = fpps_pkg::ALARM_SIGNAL;
      upd2.alarm = 32'd0;
      if (ent.st == fpps_pkg::ST_PAUSED) begin
        upd2.st = fpps_pkg::ST_READY;
      end
    end

    res = '0;
    if (pass2) begin
      res.upd   = upd2;
      res.wr    = 1'b1;
      res.ready = (upd2.st == fpps_pkg::ST_READY);
    end else begin
      res.upd   = upd1;
      res.wr    = (upd1.st != ent.st);
      res.alive = (upd1.st != fpps_pkg::ST_TERMINATED);
      res.ready = (upd1.st == fpps_pkg::ST_READY);
      if (ent.st == fpps_pkg::ST_SLEEPING) begin
        res.evt      = 1'b1;
        res.evt_tick = t_wake;
      end else if (ent.st == fpps_pkg::ST_PAUSED && ent.alarm != 32'd0) begin
        res.evt      = 1'b1;
        res.evt_tick = t_alarm;
      end
    end
  end

endmodule

FILE: rtl/fixed_priority_process_scheduler.sv
// Channel   Dir  Payload                                                 Handshake
// in_ch     in   cmd slot proc_state prio wake_at alarm_at signal_in      valid/ready
//                tick_value
// out_ch    out  status chosen_slot now_tick chosen_signal               valid/ready
//
// Write and set-tick commands go straight to S_FINISH. A schedule command scans
// the table and decides in S_DECIDE, scanning again when the tick counter has to
// advance; each pass reads the table through one port.
// Reset is synchronous; every entry reads as terminated until it is written.
// A result waiting on out_ch does not block the next input beat, but a second
// result waits in the final state until the output register frees up.
module fixed_priority_process_scheduler #(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  fpps_in_if.sink     in_ch,
  fpps_out_if.source  out_ch
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_FINISH = 4'b1000
  } fsm_t;

  fsm_t state_r, state_nxt;

  // Tick counter and scheduler registers.
  logic [31:0]            tick_r, tick_nxt;
  logic [31:0]            first_r, first_nxt;
  logic [IDX_W-1:0]       running_r, running_nxt;
  logic                   pass2_r, pass2_nxt;

  // Scan pipeline: issue_r walks read addresses, pend_* marks the entry whose
  // read data is on the memory output in this cycle.
  logic [CNT_W-1:0]       issue_r, issue_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0]       pend_idx_r, pend_idx_nxt;

  // One valid bit per table entry stands in for clearing the memory.
  logic [NUM_SLOTS-1:0]   vld_r, vld_nxt;

  // Scan accumulators.
  logic                   alive_r, alive_nxt;
  logic                   best_found_r, best_found_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  fpps_pkg::entry_t       best_word_r, best_word_nxt;
  logic                   evt_found_r, evt_found_nxt;
  logic [31:0]            evt_min_r, evt_min_nxt;

  // Result waiting to enter the output register.
  logic [1:0]             res_status_r, res_status_nxt;
  logic [3:0]             res_chosen_r, res_chosen_nxt;
  logic [4:0]             res_sig_r, res_sig_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_status_r, out_status_nxt;
  logic [3:0]             out_chosen_r, out_chosen_nxt;
  logic [31:0]            out_tick_r, out_tick_nxt;
  logic [4:0]             out_sig_r, out_sig_nxt;

  // Table memory ports.
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  fpps_pkg::entry_t       ram_wdata;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_raddr;
  logic [fpps_pkg::ENTRY_W-1:0] ram_rdata;

  fpps_pkg::entry_t       cur_ent;
  fpps_pkg::eval_t        ev;
  logic                   in_fire;

  fpps_ram #(
    .WIDTH (fpps_pkg::ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // An entry never written reads with its reset contents.
  assign cur_ent = vld_r[pend_idx_r] ? fpps_pkg::entry_t'(ram_rdata) : fpps_pkg::ENTRY_RESET;

  // In the second pass the tick counter already holds the stop tick.
  fpps_eval u_eval (
    .ent        (cur_ent),
    .pass2      (pass2_r),
    .is_run     (pend_idx_r == running_r),
    .first_tick (first_r),
    .stop_tick  (tick_r),
    .res        (ev)
  );

  assign in_ch.ready          = (state_r == S_IDLE);
  assign in_fire              = in_ch.valid && in_ch.ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.chosen_slot   = out_chosen_r;
  assign out_ch.now_tick      = out_tick_r;
  assign out_ch.chosen_signal = out_sig_r;

  always_comb begin
    state_nxt      = state_r;
    tick_nxt       = tick_r;
    first_nxt      = first_r;
    running_nxt    = running_r;
    pass2_nxt      = pass2_r;
    issue_nxt      = issue_r;
    pend_vld_nxt   = pend_vld_r;
    pend_idx_nxt   = pend_idx_r;
    vld_nxt        = vld_r;
    alive_nxt      = alive_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_word_nxt  = best_word_r;
    evt_found_nxt  = evt_found_r;
    evt_min_nxt    = evt_min_r;
    res_status_nxt = res_status_r;
    res_chosen_nxt = res_chosen_r;
    res_sig_nxt    = res_sig_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_chosen_nxt = out_chosen_r;
    out_tick_nxt   = out_tick_r;
    out_sig_nxt    = out_sig_r;

    ram_we    = 1'b0;
    ram_waddr = pend_idx_r;
    ram_wdata = ev.upd;
    ram_re    = 1'b0;
    ram_raddr = issue_r[IDX_W-1:0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_status_nxt = fpps_pkg::STAT_WRITTEN;
          res_chosen_nxt = 4'd0;
          res_sig_nxt    = 5'd0;
          state_nxt      = S_FINISH;
          case (in_ch.cmd)
            fpps_pkg::CMD_WRITE: begin
              // Slots beyond the table are ignored.
              if (32'(in_ch.slot) < NUM_SLOTS) begin
                ram_we          = 1'b1;
                ram_waddr       = IDX_W'(in_ch.slot);
                ram_wdata.st    = in_ch.proc_state;
                ram_wdata.prio  = in_ch.prio;
                ram_wdata.wake  = in_ch.wake_at;
                ram_wdata.alarm = in_ch.alarm_at;
                ram_wdata.sig   = in_ch.signal_in;
                vld_nxt[IDX_W'(in_ch.slot)] = 1'b1;
              end
            end
            fpps_pkg::CMD_SET_TICK: begin
              tick_nxt = in_ch.tick_value;
            end
            fpps_pkg::CMD_SCHEDULE: begin
              first_nxt      = tick_r + 32'd1;
              pass2_nxt      = 1'b0;
              issue_nxt      = '0;
              pend_vld_nxt   = 1'b0;
              alive_nxt      = 1'b0;
              best_found_nxt = 1'b0;
              evt_found_nxt  = 1'b0;
              state_nxt      = S_SCAN;
            end
            default: begin
              // Unknown command: report the tick counter and change nothing.
            end
          endcase
        end
      end

      S_SCAN: begin
        if (issue_r < CNT_W'(NUM_SLOTS)) begin
          ram_re       = 1'b1;
          issue_nxt    = issue_r + CNT_W'(1);
          pend_vld_nxt = 1'b1;
          pend_idx_nxt = issue_r[IDX_W-1:0];
        end else begin
          pend_vld_nxt = 1'b0;
        end
        if (pend_vld_r) begin
          // Write-back goes to the previous address while the next one is read,
          // so a read never meets a write to the same entry.
          if (ev.wr) begin
            ram_we              = 1'b1;
            vld_nxt[pend_idx_r] = 1'b1;
          end
          if (ev.alive) begin
            alive_nxt = 1'b1;
          end
          // Strictly greater keeps the lowest slot on equal priority.
          if (ev.ready && (!best_found_r || ev.upd.prio > best_word_r.prio)) begin
            best_found_nxt = 1'b1;
            best_idx_nxt   = pend_idx_r;
            best_word_nxt  = ev.upd;
          end
          if (ev.evt && (!evt_found_r || ev.evt_tick < evt_min_r)) begin
            evt_found_nxt = 1'b1;
            evt_min_nxt   = ev.evt_tick;
          end
          if (pend_idx_r == LAST_IDX) begin
            state_nxt = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        res_chosen_nxt = 4'd0;
        res_sig_nxt    = 5'd0;
        state_nxt      = S_FINISH;
        if (best_found_r) begin
          ram_we         = 1'b1;
          ram_waddr      = best_idx_r;
          ram_wdata      = best_word_r;
          ram_wdata.st   = fpps_pkg::ST_RUNNING;
          vld_nxt[best_idx_r] = 1'b1;
          running_nxt    = best_idx_r;
          res_status_nxt = fpps_pkg::STAT_SCHEDULED;
          res_chosen_nxt = 4'(best_idx_r);
          res_sig_nxt    = best_word_r.sig;
        end else if (!pass2_r && !alive_r) begin
          res_status_nxt = fpps_pkg::STAT_HALT;
        end else if (!pass2_r && evt_found_r) begin
          // Jump to the first tick at which something wakes, then rescan.
          tick_nxt       = evt_min_r;
          pass2_nxt      = 1'b1;
          issue_nxt      = '0;
          pend_vld_nxt   = 1'b0;
          best_found_nxt = 1'b0;
          state_nxt      = S_SCAN;
        end else begin
          res_status_nxt = fpps_pkg::STAT_DEADLOCK;
        end
      end

      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_chosen_nxt = res_chosen_r;
          out_tick_nxt   = tick_r;
          out_sig_nxt    = res_sig_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= 32'd0;
      running_r   <= '0;
      vld_r       <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      running_r   <= running_nxt;
      vld_r       <= vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r      <= first_nxt;
    pass2_r      <= pass2_nxt;
    issue_r      <= issue_nxt;
    pend_idx_r   <= pend_idx_nxt;
    alive_r      <= alive_nxt;
    best_found_r <= best_found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_word_r  <= best_word_nxt;
    evt_found_r  <= evt_found_nxt;
    evt_min_r    <= evt_min_nxt;
    res_status_r <= res_status_nxt;
    res_chosen_r <= res_chosen_nxt;
    res_sig_r    <= res_sig_nxt;
    out_status_r <= out_status_nxt;
    out_chosen_r <= out_chosen_nxt;
    out_tick_r   <= out_tick_nxt;
    out_sig_r    <= out_sig_nxt;
  end

endmodule
